[sv/cdm_pkg.sv]
// ---------------------------------------------------------------------------
// cdm_pkg
// Shared constants, types and angle table for the concentric disk mapper.
// ---------------------------------------------------------------------------
package cdm_pkg;

  localparam int FracBitsDef     = 16;
  localparam int CordicStagesDef = 16;
  localparam int AtanEntries     = 24;
  localparam int QueueDepth      = 4;

  localparam logic [29:0] Pi4Q30       = 30'd843314856;
  localparam logic [29:0] CordicGainInv = 30'd652032874;

  localparam logic [1:0] RegionE = 2'd0;
  localparam logic [1:0] RegionN = 2'd1;
  localparam logic [1:0] RegionW = 2'd2;
  localparam logic [1:0] RegionS = 2'd3;

  // Classified sample handed from front to back.
  typedef struct packed {
    logic [1:0]  region;
    logic [16:0] r_mag;   // radius, units of 2^-16, 0..65536
    logic [16:0] num_mag;
    logic [16:0] den_mag;
    logic        neg;
    logic        end_flag;
  } cdm_item_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] t;
    unique case (i)
      0: t = 30'h3243F6A8;  1: t = 30'h1DAC6705;  2: t = 30'h0FADBAFC;
      3: t = 30'h07F56EA6;  4: t = 30'h03FEAB76;  5: t = 30'h01FFD55B;
      6: t = 30'h00FFFAAA;  7: t = 30'h007FFF55;  8: t = 30'h003FFFEA;
      9: t = 30'h001FFFFD; 10: t = 30'h000FFFFF; 11: t = 30'h0007FFFF;
      12: t = 30'h0003FFFF; 13: t = 30'h0001FFFF; 14: t = 30'h0000FFFF;
      15: t = 30'h00007FFF; 16: t = 30'h00003FFF; 17: t = 30'h00001FFF;
      18: t = 30'h00000FFF; 19: t = 30'h000007FF; 20: t = 30'h000003FF;
      21: t = 30'h000001FF; 22: t = 30'h000000FF; 23: t = 30'h0000007F;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

[sv/cdm_front.sv]
// ---------------------------------------------------------------------------
// cdm_front
// Scales a sample to [-1,1), picks the region and the radius, numerator and
// denominator magnitudes. One registered stage with skid-free valid/ready.
// ---------------------------------------------------------------------------
module cdm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         sample_u,
  input  logic [15:0]         sample_v,
  input  logic                end_of_set,
  output logic                f_valid,
  input  logic                f_ready,
  output cdm_pkg::cdm_item_t  f_item
);
  import cdm_pkg::*;

  logic        valid_r;
  cdm_item_t   item_r, item_nxt;
  logic signed [17:0] x, y, nx, ny;

  assign in_ready = !valid_r || f_ready;
  assign f_valid  = valid_r;
  assign f_item   = item_r;

  always_comb begin
    x = $signed({1'b0, sample_u, 1'b0}) - 18'sd65536;
    y = $signed({1'b0, sample_v, 1'b0}) - 18'sd65536;
    nx = -x;
    ny = -y;
    item_nxt = '0;
    item_nxt.end_flag = end_of_set;
    if (x > ny) begin
      if (x > y) begin
        item_nxt.region = RegionE;
        item_nxt.r_mag = x[16:0];
        item_nxt.num_mag = y[17] ? ny[16:0] : y[16:0];
        item_nxt.den_mag = x[16:0];
        item_nxt.neg = y[17];
      end else begin
        item_nxt.region = RegionN;
        item_nxt.r_mag = y[16:0];
        item_nxt.num_mag = x[17] ? nx[16:0] : x[16:0];
        item_nxt.den_mag = y[16:0];
        item_nxt.neg = (nx[17] != 1'b0);
      end
    end else begin
      if (x < y) begin
        item_nxt.region = RegionW;
        item_nxt.r_mag = nx[16:0];
        item_nxt.num_mag = y[17] ? ny[16:0] : y[16:0];
        item_nxt.den_mag = nx[16:0];
        item_nxt.neg = (y[17] != x[17]) && (y != 0) && (x != 0);
      end else begin
        item_nxt.region = RegionS;
        item_nxt.r_mag = ny[16:0];
        item_nxt.num_mag = x[17] ? nx[16:0] : x[16:0];
        item_nxt.den_mag = ny[16:0];
        item_nxt.neg = (nx[17] != y[17]) && (x != 0) && (y != 0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

[sv/cdm_queue.sv]
// ---------------------------------------------------------------------------
// cdm_queue
// Short FIFO between front and back; full throughput except while full, four-entry register file.
// ---------------------------------------------------------------------------
module cdm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                w_valid,
  output logic                w_ready,
  input  cdm_pkg::cdm_item_t  w_item,
  output logic                r_valid,
  input  logic                r_ready,
  output cdm_pkg::cdm_item_t  r_item
);
  import cdm_pkg::*;

  localparam int AW = $clog2(QueueDepth);

  cdm_item_t       mem_r [QueueDepth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            push, pop;

  assign w_ready = (cnt_r != (AW+1)'(QueueDepth));
  assign r_valid = (cnt_r != '0);
  assign r_item  = mem_r[rp_r];
  assign push    = w_valid && w_ready;
  assign pop     = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= w_item;
  end

endmodule

[sv/cdm_back.sv]
// ---------------------------------------------------------------------------
// cdm_back
// Pipelined ratio divider, angle scaling, CORDIC, radius multiply, region
// rotation and saturation. Whole pipeline stalls when the output is held.
// ---------------------------------------------------------------------------
module cdm_back #(
  parameter int FRAC_BITS     = cdm_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = cdm_pkg::CordicStagesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                b_valid,
  output logic                b_ready,
  input  cdm_pkg::cdm_item_t  b_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  disk_x,
  output logic signed [15:0]  disk_y,
  output logic                end_out
);
  import cdm_pkg::*;

  localparam int QB  = FRAC_BITS + 1;           // quotient bits, t <= 1.0
  localparam int NS  = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int RW  = 17 + FRAC_BITS;          // dividend remainder width
  localparam int PW  = QB + 30;

  // divider: one quotient bit per stage, QB stages
  logic [QB:0]        dv_v_r;
  logic [RW-1:0]      dv_rem_r [QB+1];
  logic [16:0]        dv_den_r [QB+1];
  logic [QB-1:0]      dv_q_r   [QB+1];
  cdm_item_t          dv_it_r  [QB+1];

  // angle scaling: product then shift
  logic               sc_v_r;
  logic [PW-1:0]      sc_p_r;
  cdm_item_t          sc_it_r;
  logic               an_v_r;
  logic signed [31:0] an_z_r;
  cdm_item_t          an_it_r;

  // cordic
  logic [NS:0]        cr_v_r;
  logic signed [31:0] cr_c_r [NS+1];
  logic signed [31:0] cr_s_r [NS+1];
  logic signed [31:0] cr_z_r [NS+1];
  cdm_item_t          cr_it_r [NS+1];

  // multiply and output
  logic               ml_v_r;
  logic signed [49:0] ml_c_r, ml_s_r;
  cdm_item_t          ml_it_r;
  logic               out_v_r;
  logic signed [15:0] ox_r, oy_r;
  logic               oe_r;

  logic adv;
  assign adv      = !out_v_r || out_ready;
  assign b_ready  = adv;
  assign out_valid = out_v_r;
  assign disk_x   = ox_r;
  assign disk_y   = oy_r;
  assign end_out  = oe_r;

  // divider stage zero load; the dividend bits above the quotient range
  // form the starting remainder
  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= b_valid;
    if (adv) begin
      dv_rem_r[0] <= RW'(b_item.num_mag >> 1);
      dv_den_r[0] <= b_item.den_mag;
      dv_q_r[0]   <= '0;
      dv_it_r[0]  <= b_item;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW:0]   sh;
    logic [RW:0]   tr;
    logic          bit_in;
    always_comb begin
      // dividend = num << FRAC_BITS: only the first stage brings in a num bit
      bit_in = (k == 0) ? dv_it_r[k].num_mag[0] : 1'b0;
      sh = {dv_rem_r[k], bit_in};
      tr = sh - {{(RW-16){1'b0}}, dv_den_r[k]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else if (adv) dv_v_r[k+1] <= dv_v_r[k];
      if (adv) begin
        dv_den_r[k+1] <= dv_den_r[k];
        dv_it_r[k+1]  <= dv_it_r[k];
        if (!tr[RW] && dv_den_r[k] != '0) begin
          dv_rem_r[k+1] <= tr[RW-1:0];
          dv_q_r[k+1]   <= {dv_q_r[k][QB-2:0], 1'b1};
        end else begin
          dv_rem_r[k+1] <= sh[RW-1:0];
          dv_q_r[k+1]   <= {dv_q_r[k][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
      an_v_r <= 1'b0;
    end else if (adv) begin
      sc_v_r <= dv_v_r[QB];
      an_v_r <= sc_v_r;
    end
    if (adv) begin
      sc_p_r  <= PW'(dv_q_r[QB]) * PW'(Pi4Q30);
      sc_it_r <= dv_it_r[QB];
      an_it_r <= sc_it_r;
      if (sc_it_r.den_mag == '0)
        an_z_r <= '0;
      else if (sc_it_r.neg)
        an_z_r <= -$signed(32'(sc_p_r >> FRAC_BITS));
      else
        an_z_r <= $signed(32'(sc_p_r >> FRAC_BITS));
    end
  end

  assign cr_v_r[0] = an_v_r;
  assign cr_c_r[0] = 32'(CordicGainInv);
  assign cr_s_r[0] = '0;
  assign cr_z_r[0] = an_z_r;
  assign cr_it_r[0] = an_it_r;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [31:0] dc, ds, at;
    assign dc = cr_s_r[i] >>> i;
    assign ds = cr_c_r[i] >>> i;
    assign at = $signed({2'b00, atan_q30(i)});
    always_ff @(posedge clk) begin
      if (!rst_n) cr_v_r[i+1] <= 1'b0;
      else if (adv) cr_v_r[i+1] <= cr_v_r[i];
      if (adv) begin
        cr_it_r[i+1] <= cr_it_r[i];
        if (!cr_z_r[i][31]) begin
          cr_c_r[i+1] <= cr_c_r[i] - dc;
          cr_s_r[i+1] <= cr_s_r[i] + ds;
          cr_z_r[i+1] <= cr_z_r[i] - at;
        end else begin
          cr_c_r[i+1] <= cr_c_r[i] + dc;
          cr_s_r[i+1] <= cr_s_r[i] - ds;
          cr_z_r[i+1] <= cr_z_r[i] + at;
        end
      end
    end
  end

  logic signed [18:0] rc, rs;
  logic signed [15:0] sx, sy;
  logic signed [19:0] ax, ay;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sd32767;
    if (v < -20'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  always_comb begin
    rc = 19'((ml_c_r + 50'sd1073741824) >>> 31);
    rs = 19'((ml_s_r + 50'sd1073741824) >>> 31);
    unique case (ml_it_r.region)
      RegionE: begin ax = 20'(rc);  ay = 20'(rs);  end
      RegionN: begin ax = -20'(rs); ay = 20'(rc);  end
      RegionW: begin ax = -20'(rc); ay = -20'(rs); end
      default: begin ax = 20'(rs);  ay = -20'(rc); end
    endcase
    sx = sat16(ax);
    sy = sat16(ay);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      ml_v_r  <= cr_v_r[NS];
      out_v_r <= ml_v_r;
    end
    if (adv) begin
      ml_c_r  <= $signed({1'b0, cr_it_r[NS].r_mag}) * cr_c_r[NS];
      ml_s_r  <= $signed({1'b0, cr_it_r[NS].r_mag}) * cr_s_r[NS];
      ml_it_r <= cr_it_r[NS];
      ox_r <= sx;
      oy_r <= sy;
      oe_r <= ml_it_r.end_flag;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(disk_x) && $stable(disk_y))
    else $error("output changed while stalled");
  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !b_ready)
    else $error("back accepted while output stalled");
  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    an_v_r && an_it_r.den_mag == '0 |-> an_z_r == '0)
    else $error("origin angle not zero");

endmodule

[sv/concentric_disk_mapper.sv]
// Pipeline: the front register, the queue, a load stage plus FRAC_BITS+1 divider
// stages, 2 angle stages, min(CORDIC_STAGES,24) rotation stages and 2 output
// stages. Throughput: one item per cycle while the output is not held;
// the pipelined divider and CORDIC set the depth.
// Reset: synchronous active-low rst_n clears all valid flags and queue pointers.
// ---------------------------------------------------------------------------
// concentric_disk_mapper
// Maps unit-square samples to the unit disk by the concentric mapping.
// ---------------------------------------------------------------------------
module concentric_disk_mapper #(
  parameter int FRAC_BITS     = cdm_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = cdm_pkg::CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_sample_u,
  input  logic [15:0]        in_sample_v,
  input  logic               in_end_of_set,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_disk_x,
  output logic signed [15:0] out_disk_y,
  output logic               out_end_out
);
  import cdm_pkg::*;

  logic      f_valid, f_ready, q_valid, q_ready;
  cdm_item_t f_item, q_item;

  cdm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .sample_u(in_sample_u), .sample_v(in_sample_v), .end_of_set(in_end_of_set),
    .f_valid, .f_ready, .f_item
  );

  cdm_queue u_queue (
    .clk, .rst_n,
    .w_valid(f_valid), .w_ready(f_ready), .w_item(f_item),
    .r_valid(q_valid), .r_ready(q_ready), .r_item(q_item)
  );

  cdm_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk, .rst_n,
    .b_valid(q_valid), .b_ready(q_ready), .b_item(q_item),
    .out_valid, .out_ready,
    .disk_x(out_disk_x), .disk_y(out_disk_y), .end_out(out_end_out)
  );

endmodule
